@@ hw/rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment intersection tolerance package
// Shared widths, payload structs and pipeline carry structs for the
// tolerant segment meeting test.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Coordinates are signed Q16.16. The binary point cancels in every
  // comparison, so only the word width matters to the logic.
  localparam int CoordBits = 32;
  localparam int TolBits   = 31;
  localparam logic [TolBits-1:0] TolReset = TolBits'(66);

  // Derived widths of the datapath.
  localparam int DiffBits = CoordBits + 1;              // coordinate differences
  localparam int ProdBits = 2 * DiffBits + 1;           // cross and dot products
  localparam int RootBits = DiffBits + 1;               // truncated segment lengths
  localparam int QuotBits = CoordBits + 2;              // quotient bits kept
  localparam int NumBits  = ProdBits + DiffBits;        // division numerators
  localparam int WideBits = ProdBits + RootBits + 2;    // tolerance comparisons

  typedef logic signed [CoordBits-1:0] sit_coord_t;
  typedef logic signed [DiffBits-1:0]  sit_diff_t;
  typedef logic signed [ProdBits-1:0]  sit_prod_t;

  // Input transaction: segments AB and CD.
  typedef struct packed {
    sit_coord_t first_start_x;
    sit_coord_t first_start_y;
    sit_coord_t first_end_x;
    sit_coord_t first_end_y;
    sit_coord_t second_start_x;
    sit_coord_t second_start_y;
    sit_coord_t second_end_x;
    sit_coord_t second_end_y;
  } sit_in_t;

  // Output transaction: meeting flag and point.
  typedef struct packed {
    logic       meets;
    sit_coord_t meet_x;
    sit_coord_t meet_y;
  } sit_out_t;

  // Carried alongside the difference products.
  typedef struct packed {
    sit_coord_t ax;
    sit_coord_t ay;
    sit_diff_t  rx;
    sit_diff_t  ry;
  } sit_pre_carry_t;

  // Carried alongside the square roots.
  typedef struct packed {
    sit_coord_t ax;
    sit_coord_t ay;
    sit_diff_t  rx;
    sit_diff_t  ry;
    sit_prod_t  den;
    sit_prod_t  nt;
    sit_prod_t  nu;
    sit_prod_t  absnu;
    sit_prod_t  lr2;
    sit_prod_t  lo;
    sit_prod_t  hi;
  } sit_sq_carry_t;

  // Carried alongside the tolerance products.
  typedef struct packed {
    sit_coord_t ax;
    sit_coord_t ay;
    sit_diff_t  rx;
    sit_diff_t  ry;
    sit_prod_t  den;
    sit_prod_t  nt;
    sit_prod_t  absnu;
    sit_prod_t  lr2;
    sit_prod_t  lo;
  } sit_cmp_carry_t;

  // Carried alongside the numerator products.
  typedef struct packed {
    sit_coord_t ax;
    sit_coord_t ay;
    logic       meets;
    sit_prod_t  dv;
  } sit_num_carry_t;

  // Carried alongside the dividers.
  typedef struct packed {
    sit_coord_t ax;
    sit_coord_t ay;
    logic       meets;
    logic       neg_x;
    logic       neg_y;
  } sit_div_carry_t;

endpackage

@@ hw/rtl/sit_pipe.sv @@
// ----------------------------------------------------------------------------
// Valid and payload delay line
// Moves a valid bit and its payload through a fixed number of stages,
// advancing only while the pipeline enable is high.
// ----------------------------------------------------------------------------
module sit_pipe #(
  parameter int W     = 8,
  parameter int Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic         valid_q [Depth];
  logic [W-1:0] data_q  [Depth];

  for (genvar k = 0; k < Depth; k++) begin : gen_stage
    logic         valid_c;
    logic [W-1:0] data_c;

    if (k == 0) begin : gen_head
      assign valid_c = valid_i;
      assign data_c  = data_i;
    end else begin : gen_tail
      assign valid_c = valid_q[k-1];
      assign data_c  = data_q[k-1];
    end

    // Valid bits are control state and are cleared by reset.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        data_q[k] <= data_c;
      end
    end
  end

  assign valid_o = valid_q[Depth-1];
  assign data_o  = data_q[Depth-1];

endmodule

@@ hw/rtl/sit_mul.sv @@
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Splits the wide operand into 32-bit chunks, multiplies each by the narrow
// operand in the first stage and adds the shifted partials in the second.
// The wide operand must be at least 33 bits.
// ----------------------------------------------------------------------------
module sit_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int Chunks   = (WA + 31) / 32;
  localparam int TopBits  = WA - 32 * (Chunks - 1);
  localparam int PartBits = 33 + WB;
  localparam int ProdW    = WA + WB;

  logic signed [PartBits-1:0] part_q [Chunks];
  logic signed [ProdW-1:0]    sum_d;
  logic signed [ProdW-1:0]    p_q;

  // Partial products: lower chunks are unsigned, the top chunk carries the sign.
  for (genvar k = 0; k < Chunks; k++) begin : gen_part
    logic signed [32:0] op;

    if (k == Chunks - 1) begin : gen_top
      assign op = 33'($signed(a_i[WA-1 -: TopBits]));
    end else begin : gen_low
      assign op = {1'b0, a_i[32*k +: 32]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        part_q[k] <= op * b_i;
      end
    end
  end

  // Sum of the shifted partials.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < Chunks; k++) begin
      sum_d = sum_d + (ProdW'(part_q[k]) <<< (32 * k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

@@ hw/rtl/sit_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit method, one root bit per register stage. The result is the
// truncated root of the unsigned radicand.
// ----------------------------------------------------------------------------
module sit_sqrt #(
  parameter int RadW  = 67,
  parameter int RootW = 34
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RadW-1:0]  rad_i,
  output logic [RootW-1:0] root_o
);

  localparam int PadW = 2 * RootW;
  localparam int RemW = RootW + 3;

  logic [PadW-1:0]  rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : gen_step
    logic [PadW-1:0]  rad_c;
    logic [RemW-1:0]  rem_c;
    logic [RootW-1:0] root_c;
    logic [RemW-1:0]  shifted;
    logic [RemW-1:0]  trial;
    logic             fits;

    if (k == 0) begin : gen_first
      assign rad_c  = PadW'(rad_i);
      assign rem_c  = '0;
      assign root_c = '0;
    end else begin : gen_next
      assign rad_c  = rad_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
    end

    // Bring down the next two radicand bits and try a one in this root bit.
    assign shifted = {rem_c[RemW-3:0], rad_c[PadW-1-2*k -: 2]};
    assign trial   = RemW'({root_c, 2'b01});
    assign fits    = (shifted >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_c;
        rem_q[k]  <= fits ? (shifted - trial) : shifted;
        root_q[k] <= {root_c[RootW-2:0], fits};
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

@@ hw/rtl/sit_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage after a first
// stage that flags quotients too large for the kept bits.
// ----------------------------------------------------------------------------
module sit_div #(
  parameter int NumW = 100,
  parameter int DenW = 67,
  parameter int QW   = 34
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QW-1:0]   quot_o,
  output logic            ovf_o
);

  localparam int RemW = ((NumW > DenW + QW) ? NumW : DenW + QW) + 1;

  logic [RemW-1:0] rem_q  [QW+1];
  logic [DenW-1:0] den_q  [QW+1];
  logic [QW-1:0]   quot_q [QW+1];
  logic            ovf_q  [QW+1];

  // First stage: the quotient overflows when the numerator reaches den * 2^QW.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RemW'(num_i);
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= (RemW'(num_i) >= (RemW'(den_i) << QW));
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : gen_step
    localparam int Bit = QW - k;
    logic [RemW-1:0] sub;
    logic            fits;
    logic [QW-1:0]   quot_c;

    assign sub  = RemW'(den_q[k-1]) << Bit;
    assign fits = (rem_q[k-1] >= sub);

    always_comb begin
      quot_c      = quot_q[k-1];
      quot_c[Bit] = fits;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? (rem_q[k-1] - sub) : rem_q[k-1];
        den_q[k]  <= den_q[k-1];
        quot_q[k] <= quot_c;
        ovf_q[k]  <= ovf_q[k-1];
      end
    end
  end

  assign quot_o = quot_q[QW];
  assign ovf_o  = ovf_q[QW];

endmodule

@@ hw/rtl/segment_intersection_tolerance_top.sv @@
// Throughput: one transaction per cycle unless the result is stalled; the
// 34-stage root and 35-stage divider pipelines set the depth, not the rate.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the tolerance register with 66.
// ----------------------------------------------------------------------------
// Segment intersection tolerance top level
// Tests whether segments AB and CD meet within a distance tolerance and
// returns the meeting point, using a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
module segment_intersection_tolerance_top
  import sit_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sit_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sit_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [TolBits-1:0] cfg_data_i
);

  localparam int NumSq   = 14;
  localparam int SqBits  = 2 * DiffBits;
  localparam int RtBits  = RootBits + 1;
  localparam int TBits   = TolBits + 1;
  localparam int SumBits = QuotBits + 2;

  // Saturate an offset point into the coordinate range.
  function automatic sit_coord_t place(input sit_coord_t base, input logic [QuotBits-1:0] q,
                                       input logic neg, input logic ovf);
    logic signed [QuotBits:0]  sq;
    logic signed [SumBits-1:0] sum;
    sit_coord_t                res;
    sq  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = SumBits'(base) + SumBits'(sq);
    if (ovf) begin
      res = neg ? {1'b1, {(CoordBits-1){1'b0}}} : {1'b0, {(CoordBits-1){1'b1}}};
    end else if (sum[SumBits-1:CoordBits-1] != {(SumBits-CoordBits+1){sum[SumBits-1]}}) begin
      res = sum[SumBits-1] ? {1'b1, {(CoordBits-1){1'b0}}} : {1'b0, {(CoordBits-1){1'b1}}};
    end else begin
      res = sum[CoordBits-1:0];
    end
    return res;
  endfunction

  logic en;

  // --------------------------------------------------------------------------
  // Tolerance register; the port always takes a write.
  // --------------------------------------------------------------------------
  logic [TolBits-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // The whole pipeline advances unless a finished result is held by the sink.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  logic    s0_valid_q;
  sit_in_t s0_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_data_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: direction and offset vectors.
  // --------------------------------------------------------------------------
  logic       s1_valid_q;
  sit_coord_t s1_ax_q, s1_ay_q;
  sit_diff_t  s1_rx_q, s1_ry_q, s1_qx_q, s1_qy_q, s1_wx_q, s1_wy_q, s1_vx_q, s1_vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ax_q <= s0_data_q.first_start_x;
      s1_ay_q <= s0_data_q.first_start_y;
      s1_rx_q <= DiffBits'(s0_data_q.first_end_x) - DiffBits'(s0_data_q.first_start_x);
      s1_ry_q <= DiffBits'(s0_data_q.first_end_y) - DiffBits'(s0_data_q.first_start_y);
      s1_qx_q <= DiffBits'(s0_data_q.second_end_x) - DiffBits'(s0_data_q.second_start_x);
      s1_qy_q <= DiffBits'(s0_data_q.second_end_y) - DiffBits'(s0_data_q.second_start_y);
      s1_wx_q <= DiffBits'(s0_data_q.second_start_x) - DiffBits'(s0_data_q.first_start_x);
      s1_wy_q <= DiffBits'(s0_data_q.second_start_y) - DiffBits'(s0_data_q.first_start_y);
      s1_vx_q <= DiffBits'(s0_data_q.second_end_x) - DiffBits'(s0_data_q.first_start_x);
      s1_vy_q <= DiffBits'(s0_data_q.second_end_y) - DiffBits'(s0_data_q.first_start_y);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2 and 3: the selected pairwise products of the vectors listed below.
  // --------------------------------------------------------------------------
  sit_diff_t                sq_a [NumSq];
  sit_diff_t                sq_b [NumSq];
  logic signed [SqBits-1:0] sq_p [NumSq];

  always_comb begin
    sq_a[0]  = s1_rx_q;  sq_b[0]  = s1_qy_q;   // cross r x q
    sq_a[1]  = s1_ry_q;  sq_b[1]  = s1_qx_q;
    sq_a[2]  = s1_rx_q;  sq_b[2]  = s1_rx_q;   // |r|^2
    sq_a[3]  = s1_ry_q;  sq_b[3]  = s1_ry_q;
    sq_a[4]  = s1_qx_q;  sq_b[4]  = s1_qx_q;   // |q|^2
    sq_a[5]  = s1_qy_q;  sq_b[5]  = s1_qy_q;
    sq_a[6]  = s1_wx_q;  sq_b[6]  = s1_ry_q;   // cross w x r
    sq_a[7]  = s1_wy_q;  sq_b[7]  = s1_rx_q;
    sq_a[8]  = s1_wx_q;  sq_b[8]  = s1_qy_q;   // cross w x q
    sq_a[9]  = s1_wy_q;  sq_b[9]  = s1_qx_q;
    sq_a[10] = s1_wx_q;  sq_b[10] = s1_rx_q;   // projection of C on r
    sq_a[11] = s1_wy_q;  sq_b[11] = s1_ry_q;
    sq_a[12] = s1_vx_q;  sq_b[12] = s1_rx_q;   // projection of D on r
    sq_a[13] = s1_vy_q;  sq_b[13] = s1_ry_q;
  end

  for (genvar g = 0; g < NumSq; g++) begin : gen_sq_mul
    sit_mul #(
      .WA (DiffBits),
      .WB (DiffBits)
    ) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (sq_a[g]),
      .b_i   (sq_b[g]),
      .p_o   (sq_p[g])
    );
  end

  sit_pre_carry_t pre_in, pre_out;
  logic           pre_valid;

  assign pre_in = '{ax: s1_ax_q, ay: s1_ay_q, rx: s1_rx_q, ry: s1_ry_q};

  sit_pipe #(
    .W     ($bits(sit_pre_carry_t)),
    .Depth (2)
  ) u_pre_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .data_i  (pre_in),
    .valid_o (pre_valid),
    .data_o  (pre_out)
  );

  // --------------------------------------------------------------------------
  // Stage 4: cross products, squared lengths and projections.
  // --------------------------------------------------------------------------
  logic           s4_valid_q;
  sit_pre_carry_t s4_pre_q;
  sit_prod_t      s4_den_q, s4_lr2_q, s4_lq2_q, s4_nu_q, s4_nt_q, s4_dc_q, s4_dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= pre_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pre_q <= pre_out;
      s4_den_q <= ProdBits'(sq_p[0]) - ProdBits'(sq_p[1]);
      s4_lr2_q <= ProdBits'(sq_p[2]) + ProdBits'(sq_p[3]);
      s4_lq2_q <= ProdBits'(sq_p[4]) + ProdBits'(sq_p[5]);
      s4_nu_q  <= ProdBits'(sq_p[6]) - ProdBits'(sq_p[7]);
      s4_nt_q  <= ProdBits'(sq_p[8]) - ProdBits'(sq_p[9]);
      s4_dc_q  <= ProdBits'(sq_p[10]) + ProdBits'(sq_p[11]);
      s4_dd_q  <= ProdBits'(sq_p[12]) + ProdBits'(sq_p[13]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: make the cross product positive and form the projection range.
  // --------------------------------------------------------------------------
  logic          s5_valid_q;
  sit_sq_carry_t s5_carry_q;
  sit_prod_t     s5_lq2_q;
  sit_prod_t     proj_min, proj_max;

  assign proj_min = (s4_dc_q <= s4_dd_q) ? s4_dc_q : s4_dd_q;
  assign proj_max = (s4_dc_q >= s4_dd_q) ? s4_dc_q : s4_dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_carry_q.ax    <= s4_pre_q.ax;
      s5_carry_q.ay    <= s4_pre_q.ay;
      s5_carry_q.rx    <= s4_pre_q.rx;
      s5_carry_q.ry    <= s4_pre_q.ry;
      s5_carry_q.den   <= s4_den_q[ProdBits-1] ? -s4_den_q : s4_den_q;
      s5_carry_q.nt    <= s4_den_q[ProdBits-1] ? -s4_nt_q : s4_nt_q;
      s5_carry_q.nu    <= s4_den_q[ProdBits-1] ? -s4_nu_q : s4_nu_q;
      s5_carry_q.absnu <= s4_nu_q[ProdBits-1] ? -s4_nu_q : s4_nu_q;
      s5_carry_q.lr2   <= s4_lr2_q;
      s5_carry_q.lo    <= proj_min[ProdBits-1] ? '0 : proj_min;
      s5_carry_q.hi    <= (s4_lr2_q <= proj_max) ? s4_lr2_q : proj_max;
      s5_lq2_q         <= s4_lq2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Segment lengths: truncated square roots.
  // --------------------------------------------------------------------------
  logic [RootBits-1:0] lr, lq;
  sit_sq_carry_t       sq_out;
  logic                sq_valid;

  sit_sqrt #(
    .RadW  (ProdBits),
    .RootW (RootBits)
  ) u_sqrt_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s5_carry_q.lr2),
    .root_o (lr)
  );

  sit_sqrt #(
    .RadW  (ProdBits),
    .RootW (RootBits)
  ) u_sqrt_q (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s5_lq2_q),
    .root_o (lq)
  );

  sit_pipe #(
    .W     ($bits(sit_sq_carry_t)),
    .Depth (RootBits)
  ) u_sq_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_valid_q),
    .data_i  (s5_carry_q),
    .valid_o (sq_valid),
    .data_o  (sq_out)
  );

  // --------------------------------------------------------------------------
  // Tolerance products for both branches.
  // --------------------------------------------------------------------------
  logic signed [RtBits-1:0]       lr_s, lq_s, lmax_s;
  logic signed [TBits-1:0]        tol_s;
  logic signed [RtBits+TBits-1:0] p_tmax, p_tlr;
  logic signed [ProdBits+TBits-1:0]  p_td, p_tl2;
  logic signed [ProdBits+RtBits-1:0] p_ntl, p_nul, p_dlr, p_dlq, p_lol, p_hil;

  assign lr_s   = {1'b0, lr};
  assign lq_s   = {1'b0, lq};
  assign lmax_s = (lr >= lq) ? lr_s : lq_s;
  assign tol_s  = {1'b0, tol_q};

  sit_mul #(.WA(RtBits),   .WB(TBits))  u_mul_tmax (.clk_i(clk_i), .en_i(en),
    .a_i(lmax_s),     .b_i(tol_s), .p_o(p_tmax));
  sit_mul #(.WA(RtBits),   .WB(TBits))  u_mul_tlr  (.clk_i(clk_i), .en_i(en),
    .a_i(lr_s),       .b_i(tol_s), .p_o(p_tlr));
  sit_mul #(.WA(ProdBits), .WB(TBits))  u_mul_td   (.clk_i(clk_i), .en_i(en),
    .a_i(sq_out.den), .b_i(tol_s), .p_o(p_td));
  sit_mul #(.WA(ProdBits), .WB(TBits))  u_mul_tl2  (.clk_i(clk_i), .en_i(en),
    .a_i(sq_out.lr2), .b_i(tol_s), .p_o(p_tl2));
  sit_mul #(.WA(ProdBits), .WB(RtBits)) u_mul_ntl  (.clk_i(clk_i), .en_i(en),
    .a_i(sq_out.nt),  .b_i(lr_s),  .p_o(p_ntl));
  sit_mul #(.WA(ProdBits), .WB(RtBits)) u_mul_nul  (.clk_i(clk_i), .en_i(en),
    .a_i(sq_out.nu),  .b_i(lq_s),  .p_o(p_nul));
  sit_mul #(.WA(ProdBits), .WB(RtBits)) u_mul_dlr  (.clk_i(clk_i), .en_i(en),
    .a_i(sq_out.den), .b_i(lr_s),  .p_o(p_dlr));
  sit_mul #(.WA(ProdBits), .WB(RtBits)) u_mul_dlq  (.clk_i(clk_i), .en_i(en),
    .a_i(sq_out.den), .b_i(lq_s),  .p_o(p_dlq));
  sit_mul #(.WA(ProdBits), .WB(RtBits)) u_mul_lol  (.clk_i(clk_i), .en_i(en),
    .a_i(sq_out.lo),  .b_i(lr_s),  .p_o(p_lol));
  sit_mul #(.WA(ProdBits), .WB(RtBits)) u_mul_hil  (.clk_i(clk_i), .en_i(en),
    .a_i(sq_out.hi),  .b_i(lr_s),  .p_o(p_hil));

  sit_cmp_carry_t cmp_in, cmp_out;
  logic           cmp_valid;

  assign cmp_in = '{ax: sq_out.ax, ay: sq_out.ay, rx: sq_out.rx, ry: sq_out.ry,
                    den: sq_out.den, nt: sq_out.nt, absnu: sq_out.absnu,
                    lr2: sq_out.lr2, lo: sq_out.lo};

  sit_pipe #(
    .W     ($bits(sit_cmp_carry_t)),
    .Depth (2)
  ) u_cmp_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .data_i  (cmp_in),
    .valid_o (cmp_valid),
    .data_o  (cmp_out)
  );

  // --------------------------------------------------------------------------
  // Comparison stage: branch choice, meeting test and division operands.
  // --------------------------------------------------------------------------
  logic signed [WideBits-1:0] w_tmax, w_tlr, w_td, w_tl2, w_ntl, w_nul;
  logic signed [WideBits-1:0] w_dlr, w_dlq, w_lol, w_hil, w_den, w_absnu;
  logic                       crossing, ok_cross, ok_par;
  sit_prod_t                  clamp_nt;

  assign w_tmax  = WideBits'(p_tmax);
  assign w_tlr   = WideBits'(p_tlr);
  assign w_td    = WideBits'(p_td);
  assign w_tl2   = WideBits'(p_tl2);
  assign w_ntl   = WideBits'(p_ntl);
  assign w_nul   = WideBits'(p_nul);
  assign w_dlr   = WideBits'(p_dlr);
  assign w_dlq   = WideBits'(p_dlq);
  assign w_lol   = WideBits'(p_lol);
  assign w_hil   = WideBits'(p_hil);
  assign w_den   = WideBits'(cmp_out.den);
  assign w_absnu = WideBits'(cmp_out.absnu);

  // The pair is treated as crossing when |r x q| clears the tolerance slack.
  assign crossing = (w_den > w_tmax);
  assign ok_cross = ((w_ntl + w_td) >= 0) && (w_ntl <= (w_dlr + w_td)) &&
                    ((w_nul + w_td) >= 0) && (w_nul <= (w_dlq + w_td));
  assign ok_par   = (w_absnu <= w_tlr) && (cmp_out.lr2 > 0) && (w_lol <= (w_hil + w_tl2));

  // Clamping t to [0,1] turns into clamping its numerator to [0,den].
  always_comb begin
    if (cmp_out.nt <= 0) begin
      clamp_nt = '0;
    end else if (cmp_out.nt >= cmp_out.den) begin
      clamp_nt = cmp_out.den;
    end else begin
      clamp_nt = cmp_out.nt;
    end
  end

  logic       c_valid_q;
  logic       c_meets_q;
  sit_prod_t  c_fac_q, c_dv_q;
  sit_coord_t c_ax_q, c_ay_q;
  sit_diff_t  c_rx_q, c_ry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= cmp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_meets_q <= crossing ? ok_cross : ok_par;
      c_fac_q   <= crossing ? clamp_nt : cmp_out.lo;
      c_dv_q    <= crossing ? cmp_out.den : cmp_out.lr2;
      c_ax_q    <= cmp_out.ax;
      c_ay_q    <= cmp_out.ay;
      c_rx_q    <= cmp_out.rx;
      c_ry_q    <= cmp_out.ry;
    end
  end

  // --------------------------------------------------------------------------
  // Numerators of the point offsets.
  // --------------------------------------------------------------------------
  logic signed [NumBits-1:0] num_x, num_y;
  sit_num_carry_t            num_in, num_out;
  logic                      num_valid;

  sit_mul #(.WA(ProdBits), .WB(DiffBits)) u_mul_nx (.clk_i(clk_i), .en_i(en),
    .a_i(c_fac_q), .b_i(c_rx_q), .p_o(num_x));
  sit_mul #(.WA(ProdBits), .WB(DiffBits)) u_mul_ny (.clk_i(clk_i), .en_i(en),
    .a_i(c_fac_q), .b_i(c_ry_q), .p_o(num_y));

  assign num_in = '{ax: c_ax_q, ay: c_ay_q, meets: c_meets_q, dv: c_dv_q};

  sit_pipe #(
    .W     ($bits(sit_num_carry_t)),
    .Depth (2)
  ) u_num_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid_q),
    .data_i  (num_in),
    .valid_o (num_valid),
    .data_o  (num_out)
  );

  // --------------------------------------------------------------------------
  // Sign and magnitude ahead of the dividers.
  // --------------------------------------------------------------------------
  logic                ab_valid_q;
  logic [NumBits-1:0]  ab_mag_x_q, ab_mag_y_q;
  logic [ProdBits-1:0] ab_dv_q;
  sit_div_carry_t      ab_carry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_valid_q <= 1'b0;
    end else if (en) begin
      ab_valid_q <= num_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ab_mag_x_q       <= num_x[NumBits-1] ? NumBits'(-num_x) : NumBits'(num_x);
      ab_mag_y_q       <= num_y[NumBits-1] ? NumBits'(-num_y) : NumBits'(num_y);
      ab_dv_q          <= num_out.dv;
      ab_carry_q.ax    <= num_out.ax;
      ab_carry_q.ay    <= num_out.ay;
      ab_carry_q.meets <= num_out.meets;
      ab_carry_q.neg_x <= num_x[NumBits-1];
      ab_carry_q.neg_y <= num_y[NumBits-1];
    end
  end

  // --------------------------------------------------------------------------
  // Division by r x q or |r|^2.
  // --------------------------------------------------------------------------
  logic [QuotBits-1:0] quot_x, quot_y;
  logic                ovf_x, ovf_y;
  sit_div_carry_t      div_out;
  logic                div_valid;

  sit_div #(.NumW(NumBits), .DenW(ProdBits), .QW(QuotBits)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (ab_mag_x_q),
    .den_i  (ab_dv_q),
    .quot_o (quot_x),
    .ovf_o  (ovf_x)
  );

  sit_div #(.NumW(NumBits), .DenW(ProdBits), .QW(QuotBits)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (ab_mag_y_q),
    .den_i  (ab_dv_q),
    .quot_o (quot_y),
    .ovf_o  (ovf_y)
  );

  sit_pipe #(
    .W     ($bits(sit_div_carry_t)),
    .Depth (QuotBits + 1)
  ) u_div_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ab_valid_q),
    .data_i  (ab_carry_q),
    .valid_o (div_valid),
    .data_o  (div_out)
  );

  // --------------------------------------------------------------------------
  // Output register: point placement, saturation and zeroing on no meet.
  // --------------------------------------------------------------------------
  logic     out_valid_q;
  sit_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.meets  <= div_out.meets;
      out_data_q.meet_x <= div_out.meets ?
                           place(div_out.ax, quot_x, div_out.neg_x, ovf_x) : '0;
      out_data_q.meet_y <= div_out.meets ?
                           place(div_out.ay, quot_y, div_out.neg_y, ovf_y) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hw/rtl/sit_checker.sv @@
// ----------------------------------------------------------------------------
// Segment intersection tolerance port checker
// Watches the top level's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module sit_checker
  import sit_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sit_out_t out_data_o
);

  // A stalled result transaction stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction withdrawn while stalled");

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // The input side only stalls while a finished result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A pair that does not meet reports the origin as its point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.meets |-> out_data_o.meet_x == '0 && out_data_o.meet_y == '0)
    else $error("non-meeting result with a nonzero point");

endmodule

bind segment_intersection_tolerance_top sit_checker u_sit_checker (.*);
